// ===== sv/lwr_pkg.sv =====
`timescale 1ns / 1ps

package lwr_pkg;

    // field widths of the item and result words
    localparam int POS_BITS     = 32;
    localparam int DIFF_BITS    = 33;
    localparam int ANGLE_BITS   = 16;
    localparam int TRIG_BITS    = 16;
    localparam int COLUMN_BITS  = 10;

    // rotator datapath widths: vector in Q2.30 with headroom, angle in 2^32 per turn
    localparam int VEC_BITS     = 34;
    localparam int RESID_BITS   = 32;
    localparam int MAX_STAGES   = 24;

    // rotator gain compensation, Q2.30
    localparam logic signed [VEC_BITS-1:0] CORDIC_K_Q30 = 34'sd652032874;

    // quarter turn in binary angle counts
    localparam logic signed [ANGLE_BITS-1:0] QUARTER_TURN = 16'sd16384;

    // arctangent of 2^-i in units of 2^32 per turn
    localparam logic [RESID_BITS-1:0] ATAN_TURNS [MAX_STAGES] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    // input word
    typedef struct packed {
        logic signed [POS_BITS-1:0]   robot_x;
        logic signed [POS_BITS-1:0]   robot_y;
        logic        [ANGLE_BITS-1:0] robot_heading;
        logic signed [POS_BITS-1:0]   mark_x;
        logic signed [POS_BITS-1:0]   mark_y;
        logic        [COLUMN_BITS-1:0] state_column;
        logic                         batch_end;
    } lwr_in_t;

    // result word
    typedef struct packed {
        logic signed [POS_BITS-1:0]   seen_x;
        logic signed [POS_BITS-1:0]   seen_y;
        logic signed [POS_BITS-1:0]   dx_dheading;
        logic signed [POS_BITS-1:0]   dy_dheading;
        logic signed [TRIG_BITS-1:0]  cos_neg;
        logic signed [TRIG_BITS-1:0]  sin_neg;
        logic        [COLUMN_BITS-1:0] column_out;
        logic                         last;
    } lwr_out_t;

    // contents of one rotator cell, handed down the chain every cycle
    typedef struct packed {
        logic signed [VEC_BITS-1:0]    x;
        logic signed [VEC_BITS-1:0]    y;
        logic signed [RESID_BITS-1:0]  z;
        logic                          neg;
        logic signed [DIFF_BITS-1:0]   dx;
        logic signed [DIFF_BITS-1:0]   dy;
        logic        [COLUMN_BITS-1:0] column;
        logic                          last;
    } lwr_cell_t;

endpackage

// ===== sv/lwr_prep.sv =====
`timescale 1ns / 1ps

module lwr_prep #(
    parameter int COLUMN_WIDTH = 10
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              vld_in,
    input  lwr_pkg::lwr_in_t  item,
    output logic              vld_out,
    output lwr_pkg::lwr_cell_t cell_out
);
    import lwr_pkg::*;

    localparam int KEEP_BITS = (COLUMN_WIDTH < COLUMN_BITS) ? COLUMN_WIDTH : COLUMN_BITS;
    localparam logic [COLUMN_BITS-1:0] COLUMN_MASK = COLUMN_BITS'((1 << KEEP_BITS) - 1);

    logic               vld_reg;
    lwr_cell_t          cell_reg;
    lwr_cell_t          cell_next;
    logic signed [ANGLE_BITS-1:0] angle;
    logic signed [ANGLE_BITS-1:0] folded;
    logic               fold;

    // negate heading and fold into the right half plane
    always_comb
    begin
        angle  = $signed(ANGLE_BITS'(0) - item.robot_heading);
        fold   = 1'b0;
        folded = angle;
        if (angle > QUARTER_TURN)
        begin
            folded = angle - (QUARTER_TURN <<< 1);
            fold   = 1'b1;
        end
        else if (angle < -QUARTER_TURN)
        begin
            folded = angle + (QUARTER_TURN <<< 1);
            fold   = 1'b1;
        end
    end

    // offsets and rotator start vector
    always_comb
    begin
        cell_next.x      = CORDIC_K_Q30;
        cell_next.y      = '0;
        cell_next.z      = {folded, 16'd0};
        cell_next.neg    = fold;
        cell_next.dx     = DIFF_BITS'(item.mark_x) - DIFF_BITS'(item.robot_x);
        cell_next.dy     = DIFF_BITS'(item.mark_y) - DIFF_BITS'(item.robot_y);
        cell_next.column = item.state_column & COLUMN_MASK;
        cell_next.last   = item.batch_end;
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_in;
    end

    // payload
    always_ff @(posedge clk)
    begin
        cell_reg <= cell_next;
    end

    assign vld_out  = vld_reg;
    assign cell_out = cell_reg;

endmodule

// ===== sv/lwr_cordic_cell.sv =====
`timescale 1ns / 1ps

module lwr_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               vld_in,
    input  lwr_pkg::lwr_cell_t cell_in,
    output logic               vld_out,
    output lwr_pkg::lwr_cell_t cell_out
);
    import lwr_pkg::*;

    logic                       vld_reg;
    lwr_cell_t                  cell_reg;
    lwr_cell_t                  cell_next;
    logic signed [VEC_BITS-1:0] xs;
    logic signed [VEC_BITS-1:0] ys;

    // one micro-rotation, direction from the residual sign
    always_comb
    begin
        xs        = $signed(cell_in.x) >>> STAGE;
        ys        = $signed(cell_in.y) >>> STAGE;
        cell_next = cell_in;
        if (!cell_in.z[RESID_BITS-1])
        begin
            cell_next.x = $signed(cell_in.x) - ys;
            cell_next.y = $signed(cell_in.y) + xs;
            cell_next.z = $signed(cell_in.z) - $signed(ATAN_TURNS[STAGE]);
        end
        else
        begin
            cell_next.x = $signed(cell_in.x) + ys;
            cell_next.y = $signed(cell_in.y) - xs;
            cell_next.z = $signed(cell_in.z) + $signed(ATAN_TURNS[STAGE]);
        end
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_in;
    end

    // payload
    always_ff @(posedge clk)
    begin
        cell_reg <= cell_next;
    end

    assign vld_out  = vld_reg;
    assign cell_out = cell_reg;

endmodule

// ===== sv/lwr_post.sv =====
`timescale 1ns / 1ps

module lwr_post (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               vld_in,
    input  lwr_pkg::lwr_cell_t cell_in,
    output logic               done,
    output lwr_pkg::lwr_out_t  result
);
    import lwr_pkg::*;

    localparam int PROD_BITS = TRIG_BITS + DIFF_BITS;
    localparam int SUM_BITS  = PROD_BITS + 1;

    // round Q2.30 to Q1.15 and clamp
    function automatic logic signed [TRIG_BITS-1:0] trig_round(
        input logic signed [VEC_BITS-1:0] v
    );
        logic signed [VEC_BITS-1:0] t;
        begin
            t = (v + VEC_BITS'(16384)) >>> 15;
            if (t > VEC_BITS'(32767))
                trig_round = 16'sh7FFF;
            else if (t < -VEC_BITS'(32768))
                trig_round = 16'sh8000;
            else
                trig_round = t[TRIG_BITS-1:0];
        end
    endfunction

    // round 31 fraction bits to Q16.16 and clamp to 32 bits
    function automatic logic signed [POS_BITS-1:0] pos_round(
        input logic signed [SUM_BITS-1:0] v
    );
        logic signed [SUM_BITS-1:0] t;
        begin
            t = (v + SUM_BITS'(16384)) >>> 15;
            if (t > SUM_BITS'(64'sd2147483647))
                pos_round = 32'sh7FFFFFFF;
            else if (t < SUM_BITS'(-64'sd2147483648))
                pos_round = 32'sh80000000;
            else
                pos_round = t[POS_BITS-1:0];
        end
    endfunction

    logic                          v1_reg, v2_reg, v3_reg, done_reg;
    logic signed [TRIG_BITS-1:0]   c1_reg, s1_reg, c2_reg, s2_reg, c3_reg, s3_reg;
    logic signed [DIFF_BITS-1:0]   dx1_reg, dy1_reg;
    logic        [COLUMN_BITS-1:0] col1_reg, col2_reg, col3_reg;
    logic                          last1_reg, last2_reg, last3_reg;
    logic signed [PROD_BITS-1:0]   cdx_reg, sdy_reg, sdx_reg, cdy_reg;
    logic signed [SUM_BITS-1:0]    p_reg, q_reg, np_reg;
    logic signed [VEC_BITS-1:0]    xf, yf;
    lwr_out_t                      result_reg;
    lwr_out_t                      result_next;

    // undo the half-turn fold
    always_comb
    begin
        xf = cell_in.neg ? -$signed(cell_in.x) : $signed(cell_in.x);
        yf = cell_in.neg ? -$signed(cell_in.y) : $signed(cell_in.y);
    end

    // final rounding and clamping of the four outputs
    always_comb
    begin
        result_next.seen_x      = pos_round(p_reg);
        result_next.seen_y      = pos_round(q_reg);
        result_next.dx_dheading = pos_round(q_reg);
        result_next.dy_dheading = pos_round(np_reg);
        result_next.cos_neg     = c3_reg;
        result_next.sin_neg     = s3_reg;
        result_next.column_out  = col3_reg;
        result_next.last        = last3_reg;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= vld_in;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            done_reg <= v3_reg;
        end
    end

    // trig rounding, products, sums, output
    always_ff @(posedge clk)
    begin
        c1_reg    <= trig_round(xf);
        s1_reg    <= trig_round(yf);
        dx1_reg   <= cell_in.dx;
        dy1_reg   <= cell_in.dy;
        col1_reg  <= cell_in.column;
        last1_reg <= cell_in.last;

        cdx_reg   <= PROD_BITS'(c1_reg) * PROD_BITS'(dx1_reg);
        sdy_reg   <= PROD_BITS'(s1_reg) * PROD_BITS'(dy1_reg);
        sdx_reg   <= PROD_BITS'(s1_reg) * PROD_BITS'(dx1_reg);
        cdy_reg   <= PROD_BITS'(c1_reg) * PROD_BITS'(dy1_reg);
        c2_reg    <= c1_reg;
        s2_reg    <= s1_reg;
        col2_reg  <= col1_reg;
        last2_reg <= last1_reg;

        p_reg     <= SUM_BITS'(cdx_reg) - SUM_BITS'(sdy_reg);
        np_reg    <= SUM_BITS'(sdy_reg) - SUM_BITS'(cdx_reg);
        q_reg     <= SUM_BITS'(sdx_reg) + SUM_BITS'(cdy_reg);
        c3_reg    <= c2_reg;
        s3_reg    <= s2_reg;
        col3_reg  <= col2_reg;
        last3_reg <= last2_reg;

        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== sv/landmark_world_to_robot_frame.sv =====
`timescale 1ns / 1ps

// channel  | ports               | handshake
// ---------+---------------------+------------------------------------------
// input    | start, busy, item   | word taken at a clock edge with start high, busy low
// result   | done, result        | word valid for the one cycle that done is high
//
// one word per cycle; busy stays low, so a new word may follow every cycle.
// the path is one input register, one rotator cell per micro-rotation (CORDIC_STAGES,
// capped at 24 rotator cells), then round, multiply, sum and clamp.
// reset clears only the valid bits along the chain; there is no stored state.
// the receiver cannot stall, so done is a single-cycle strobe per word.

module landmark_world_to_robot_frame #(
    parameter int COLUMN_WIDTH  = 10,
    parameter int CORDIC_STAGES = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  lwr_pkg::lwr_in_t item,
    output logic             done,
    output lwr_pkg::lwr_out_t result
);
    import lwr_pkg::*;

    localparam int STAGES = (CORDIC_STAGES < MAX_STAGES) ? CORDIC_STAGES : MAX_STAGES;

    logic      vld_chain  [STAGES+1];
    lwr_cell_t cell_chain [STAGES+1];

    // fully pipelined, always ready
    assign busy = 1'b0;

    // offsets, angle fold and start vector
    lwr_prep #(
        .COLUMN_WIDTH (COLUMN_WIDTH)
    ) u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .vld_in   (start && !busy),
        .item     (item),
        .vld_out  (vld_chain[0]),
        .cell_out (cell_chain[0])
    );

    // row of rotator cells
    for (genvar i = 0; i < STAGES; i++)
    begin : g_cell
        lwr_cordic_cell #(
            .STAGE (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .vld_in   (vld_chain[i]),
            .cell_in  (cell_chain[i]),
            .vld_out  (vld_chain[i+1]),
            .cell_out (cell_chain[i+1])
        );
    end

    // trig rounding, rotation products and output clamping
    lwr_post u_post (
        .clk     (clk),
        .rst_n   (rst_n),
        .vld_in  (vld_chain[STAGES]),
        .cell_in (cell_chain[STAGES]),
        .done    (done),
        .result  (result)
    );

endmodule
